[design/cfdl_pkg.sv]
// Shared constants, types and state encoding for the crossfading delay line.
package cfdl_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned MAX_DELAY  = 4096;
  localparam int unsigned MAX_BLOCK  = 1024;
  localparam int unsigned MIN_BLOCK  = 4;
  localparam int unsigned RING_DEPTH = 8192;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned DELAY_W    = 13;
  localparam int unsigned BSIZE_W    = 11;
  localparam int unsigned POS_W      = $clog2(MAX_BLOCK);
  localparam int unsigned FADE_W     = BSIZE_W - 2;
  localparam int unsigned QFRAC      = 16;
  localparam int unsigned GAIN_W     = QFRAC + 1;
  localparam int unsigned ACC_W      = SAMPLE_W + GAIN_W + 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = DELAY_W;
  localparam int unsigned DIV_CNT_W  = $clog2(QFRAC + 1);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << QFRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY = 1'b0,
    CFG_BLOCK = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CUR,
    S_RD_OLD,
    S_SETUP,
    S_DIV,
    S_MUL,
    S_OUT
  } state_e;

  // request to the gain divider: fraction num/den, num < den
  typedef struct packed {
    logic              start;
    logic [FADE_W-1:0] num;
    logic [FADE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QFRAC-1:0] quot;
  } div_rsp_t;

endpackage

[design/cfdl_ram.sv]
// Generic simple dual-port RAM with registered read.
module cfdl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/cfdl_gain_div.sv]
// Bit-serial restoring divider producing a Q16 fraction num/den.
module cfdl_gain_div
  import cfdl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [FADE_W-1:0]    rem_q, rem_d;
  logic [FADE_W-1:0]    den_q, den_d;
  logic [QFRAC-1:0]     quo_q, quo_d;
  logic [FADE_W:0]      shifted;
  logic                 fits;

  always_comb begin
    shifted = {rem_q, 1'b0};
    fits    = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(QFRAC);
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      // remainder stays below den, so the shifted value never loses a bit
      rem_d = fits ? FADE_W'(shifted - {1'b0, den_q}) : shifted[FADE_W-1:0];
      quo_d = {quo_q[QFRAC-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

[design/crossfading_delay_line.sv]
// Crossfading delay line: 24-bit sample ring with block-wise fade-in and tap crossfade.
// Sequence: an accepted sample passes S_RD_CUR, S_RD_OLD, S_SETUP, S_MUL and S_OUT; a block
// lacking history goes from S_SETUP to S_OUT, and S_DIV runs the serial Q16 gain divider
// (16 quotient bits) before S_MUL; input stalls meanwhile, and output stalls hold S_OUT.
// Reset clears pointers, history, block position and flags and arms the fade-in; the ring
// is not cleared, and unwritten entries never reach the output.
module crossfading_delay_line
  import cfdl_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       filled_o
);

  state_e state_q, state_d;

  // configuration
  logic [DELAY_W-1:0] delay_cfg_q;
  logic [BSIZE_W-1:0] bsize_cfg_q;

  // control state
  logic [RING_AW-1:0] wp_q;
  logic [DELAY_W-1:0] hist_q;
  logic [POS_W-1:0]   pos_q;
  logic [DELAY_W-1:0] prev_delay_q;
  logic               fade_pend_q;
  logic               ready_q, fadein_q, xfade_q;
  logic [DELAY_W-1:0] blk_delay_q;
  logic [BSIZE_W-1:0] blk_len_q;
  logic               out_valid_q;

  // datapath
  logic signed [SAMPLE_W-1:0] cur_q, old_q;
  logic [GAIN_W-1:0]          g_q;
  logic                       xf_sel_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] sample_out_q;
  logic                       filled_q;

  logic               in_accept;
  logic               out_free;
  logic [RING_AW-1:0] ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // block start decisions
  logic [BSIZE_W-1:0] bs_clamped;
  logic               start_ready;

  // per-item gain selection
  logic [FADE_W-1:0]  f_w, f_m1;
  logic               pos_lt_f, xf_act;
  logic               setup_need_div;
  logic [FADE_W-1:0]  setup_den;
  logic [GAIN_W-1:0]  setup_g;

  logic signed [SAMPLE_W:0]  diff;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   acc_d;
  logic signed [ACC_W-1:0]   y_sum;
  logic [POS_W:0]            pos_inc;

  cfdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wp_q),
    .wdata_i (sample_in_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cfdl_gain_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_RD_CUR;
      S_RD_CUR: state_d = S_RD_OLD;
      S_RD_OLD: state_d = S_SETUP;
      S_SETUP: begin
        if (!ready_q) state_d = S_OUT;
        else if (setup_need_div) state_d = S_DIV;
        else state_d = S_MUL;
      end
      S_DIV:    if (div_rsp.done) state_d = S_MUL;
      S_MUL:    state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = (state_q != S_IDLE);
    in_accept     = in_valid_i && (state_q == S_IDLE);
    out_free      = !out_valid_q || !out_stall_i;
    ram_raddr     = (state_q == S_RD_CUR) ? (wp_q - blk_delay_q[RING_AW-1:0])
                                          : (wp_q - prev_delay_q[RING_AW-1:0]);
    div_req.start = (state_q == S_SETUP) && ready_q && setup_need_div;
    div_req.num   = pos_q[FADE_W-1:0];
    div_req.den   = setup_den;
  end

  // block start: clamp length, check history
  always_comb begin
    if (bsize_cfg_q < BSIZE_W'(MIN_BLOCK)) bs_clamped = BSIZE_W'(MIN_BLOCK);
    else if (bsize_cfg_q > BSIZE_W'(MAX_BLOCK)) bs_clamped = BSIZE_W'(MAX_BLOCK);
    else bs_clamped = bsize_cfg_q;
    start_ready = hist_q >= delay_cfg_q;
  end

  // gain choice; crossfade wins over fade-in in the first quarter
  always_comb begin
    f_w            = blk_len_q[BSIZE_W-1:2];
    f_m1           = f_w - FADE_W'(1);
    pos_lt_f       = pos_q < POS_W'(f_w);
    xf_act         = xfade_q && pos_lt_f;
    setup_need_div = 1'b0;
    setup_den      = f_w;
    setup_g        = GAIN_ONE;
    if (xf_act) begin
      if (f_w < FADE_W'(2)) begin
        setup_g = '0;
      end else if (pos_q != POS_W'(f_m1)) begin
        setup_need_div = 1'b1;
        setup_den      = f_m1;
      end
    end else if (fadein_q && pos_lt_f) begin
      setup_need_div = 1'b1;
    end
  end

  // weighted sum: base*2^16 + g*diff, then truncate toward zero
  always_comb begin
    diff    = xf_sel_q ? (SAMPLE_W+1)'(cur_q) - (SAMPLE_W+1)'(old_q)
                       : (SAMPLE_W+1)'(cur_q);
    base    = xf_sel_q ? (ACC_W'(old_q) <<< QFRAC) : '0;
    acc_d   = ACC_W'($signed({1'b0, g_q}) * diff) + base;
    y_sum   = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << QFRAC) - 1) : ACC_W'(0));
    pos_inc = (POS_W+1)'(pos_q) + (POS_W+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      delay_cfg_q  <= '0;
      bsize_cfg_q  <= BSIZE_W'(256);
      wp_q         <= '0;
      hist_q       <= '0;
      pos_q        <= '0;
      prev_delay_q <= '0;
      fade_pend_q  <= 1'b1;
      ready_q      <= 1'b0;
      fadein_q     <= 1'b0;
      xfade_q      <= 1'b0;
      blk_delay_q  <= '0;
      blk_len_q    <= BSIZE_W'(MIN_BLOCK);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELAY: delay_cfg_q <= cfg_data_i;
          CFG_BLOCK: bsize_cfg_q <= cfg_data_i[BSIZE_W-1:0];
          default:   ;
        endcase
      end
      if (in_accept && pos_q == '0) begin
        blk_len_q   <= bs_clamped;
        blk_delay_q <= delay_cfg_q;
        ready_q     <= start_ready;
        fadein_q    <= start_ready && fade_pend_q && (delay_cfg_q != '0);
        xfade_q     <= start_ready && (prev_delay_q != delay_cfg_q)
                       && (hist_q >= prev_delay_q);
        if (start_ready || delay_cfg_q == '0) fade_pend_q <= 1'b0;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
        wp_q        <= wp_q + RING_AW'(1);
        if (hist_q < DELAY_W'(MAX_DELAY)) hist_q <= hist_q + DELAY_W'(1);
        if (pos_inc >= (POS_W+1)'(blk_len_q)) begin
          pos_q        <= '0;
          prev_delay_q <= blk_delay_q;
        end else begin
          pos_q <= pos_inc[POS_W-1:0];
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD_OLD) cur_q <= ram_rdata;
    if (state_q == S_SETUP) begin
      old_q    <= ram_rdata;
      g_q      <= setup_g;
      xf_sel_q <= xf_act;
    end
    if (state_q == S_DIV && div_rsp.done) g_q <= {1'b0, div_rsp.quot};
    if (state_q == S_MUL) acc_q <= acc_d;
    if (state_q == S_OUT && out_free) begin
      sample_out_q <= ready_q ? y_sum[QFRAC +: SAMPLE_W] : '0;
      filled_q     <= ready_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign filled_o     = filled_q;

endmodule

[verif/tb.sv]
// Self-checking testbench for the crossfading delay line with a Q16 fade predictor.
module tb;
  import cfdl_pkg::*;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES  = 30;
  localparam int unsigned DIRECTED_ITEMS = 24;
  localparam int unsigned RANDOM_ITEMS   = 1600;
  localparam longint      Q_ONE          = 65536;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       filled;
  } tap_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  class tap_scoreboard;
    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    int wr_ptr, hist, pos, prev_delay, blk_delay, blk_len, delay_reg, bsize_reg;
    bit fade_pending, blk_ready, blk_fade, blk_xfade;
    tap_result_t expected_taps[$];
    int mismatches;

    function new();
      foreach (ring[k]) ring[k] = '0;
      wr_ptr       = 0;
      hist         = 0;
      pos          = 0;
      prev_delay   = 0;
      blk_delay    = 0;
      blk_len      = int'(MIN_BLOCK);
      delay_reg    = 0;
      bsize_reg    = 256;
      fade_pending = 1'b1;
      blk_ready    = 1'b0;
      blk_fade     = 1'b0;
      blk_xfade    = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      if (idx == CFG_DELAY) begin
        delay_reg = int'(value[DELAY_W-1:0]);
      end else begin
        bsize_reg = int'(value[BSIZE_W-1:0]);
      end
    endfunction

    function longint read_tap(int tap_dist);
      return longint'(ring[(wr_ptr + int'(RING_DEPTH) - tap_dist % int'(RING_DEPTH))
                           % int'(RING_DEPTH)]);
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      longint cur, old, g, y;
      int f;
      // delay and length are latched at the first transaction of each block
      if (pos == 0) begin
        blk_len = (bsize_reg < int'(MIN_BLOCK)) ? int'(MIN_BLOCK) :
                  (bsize_reg > int'(MAX_BLOCK)) ? int'(MAX_BLOCK) : bsize_reg;
        blk_delay = delay_reg;
        blk_ready = 1'b0;
        blk_fade  = 1'b0;
        blk_xfade = 1'b0;
        if (blk_delay == 0) fade_pending = 1'b0;
        if (hist >= blk_delay) begin
          blk_ready    = 1'b1;
          blk_fade     = fade_pending;
          fade_pending = 1'b0;
          blk_xfade    = (prev_delay != blk_delay) && (hist >= prev_delay);
        end
      end
      ring[wr_ptr] = x;
      f = blk_len / 4;
      y = 0;
      if (blk_ready) begin
        cur = read_tap(blk_delay);
        y = cur;
        if (blk_fade) begin
          g = (pos < f) ? longint'(pos) * Q_ONE / f : Q_ONE;
          y = cur * g / Q_ONE;
        end
        // crossfade overrides the fade-in over the first quarter
        if (blk_xfade && pos < f) begin
          old = read_tap(prev_delay);
          g = (f >= 2) ? longint'(pos) * Q_ONE / (f - 1) : 0;
          y = ((Q_ONE - g) * old + g * cur) / Q_ONE;
        end
      end
      expected_taps.push_back('{sample: SAMPLE_W'(y), filled: blk_ready});
      wr_ptr = (wr_ptr + 1) % int'(RING_DEPTH);
      if (hist < int'(MAX_DELAY)) hist++;
      pos++;
      if (pos >= blk_len) begin
        pos = 0;
        prev_delay = blk_delay;
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] got_sample, logic got_filled);
      tap_result_t want;
      if (expected_taps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sample %0d filled %0b", got_sample, got_filled);
        return;
      end
      want = expected_taps.pop_front();
      if (got_sample !== want.sample || got_filled !== want.filled) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected sample %0d filled %0b, got sample %0d filled %0b",
                   want.sample, want.filled, got_sample, got_filled);
      end
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i   = CFG_DELAY;
  logic [CFG_W-1:0]           cfg_data_i  = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       filled_o;

  tap_scoreboard tap_sb;
  logic signed [SAMPLE_W-1:0] directed_samples[$];
  int items_sent, burst_left, quiet_cycles, stall_left, stall_tick;
  stall_mode_e stall_mode;

  crossfading_delay_line dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .filled_o     (filled_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // receiver back-pressure: modes of random length, including stretches with none
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 400);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_tick % 9) < 4);
    endcase
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) tap_sb.note_sample(sample_in_i);
    if (out_valid_o && !out_stall_i) tap_sb.check_result(sample_out_o, filled_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL crossfading_delay_line");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_samples(int count);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8)) @(posedge clk_i);
        end
      end
      in_valid_i  <= 1'b1;
      sample_in_i <= (directed_samples.size() > 0) ? directed_samples.pop_front()
                                                   : rand_sample();
      do @(posedge clk_i); while (in_stall_o);
      burst_left--;
      items_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tap_sb.expected_taps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(int new_delay, int new_bsize);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DELAY;
    cfg_data_i <= CFG_W'(new_delay);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BLOCK;
    cfg_data_i <= CFG_W'(new_bsize);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tap_sb.write_reg(CFG_DELAY, CFG_W'(new_delay));
    tap_sb.write_reg(CFG_BLOCK, CFG_W'(new_bsize));
  endtask

  initial begin
    int hist_now, new_delay, new_bsize, last_delay;
    tap_sb = new();
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_samples = '{
      24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
      24'sh000001, 24'sh7FFFFF, 24'sh800000, 24'sh123456,
      24'sh800000, 24'sh7FFFFF, 24'sh555555, 24'shAAAAAA,
      24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
      24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'shFFFFFF,
      24'sh0F0F0F, 24'shF0F0F0, 24'sh7FFFFF, 24'sh800000
    };
    // first block short of history, then fade-in overlapped by a crossfade, then a zero-delay
    // write mid-block that never takes effect, as the samples that follow only finish that block
    set_regs(2, 8);
    send_samples(8);
    set_regs(5, 16);
    send_samples(8);
    set_regs(0, 4);
    send_samples(8);
    last_delay = 0;

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      hist_now = (items_sent < int'(MAX_DELAY)) ? items_sent : int'(MAX_DELAY);
      case ($urandom_range(0, 9))
        0:       new_delay = 0;
        1:       new_delay = last_delay;
        2:       new_delay = $urandom_range(hist_now + 1, 8191);
        3:       new_delay = hist_now;
        4, 5, 6: new_delay = $urandom_range(0, (hist_now < 40) ? hist_now : 40);
        default: new_delay = $urandom_range(0, hist_now);
      endcase
      case ($urandom_range(0, 9))
        0:       new_bsize = $urandom_range(0, 3);
        1:       new_bsize = $urandom_range(MAX_BLOCK, 2047);
        2:       new_bsize = $urandom_range(0, 8191);
        3, 4, 5: new_bsize = $urandom_range(4, 16);
        6, 7, 8: new_bsize = $urandom_range(17, 64);
        default: new_bsize = $urandom_range(65, 256);
      endcase
      last_delay = new_delay;
      set_regs(new_delay, new_bsize);
      send_samples($urandom_range(8, 160));
    end

    // delays up to and beyond the history limit, then back to zero delay
    set_regs(MAX_DELAY, 16);
    send_samples(16);
    set_regs(4000, 64);
    send_samples(128);
    set_regs(MAX_DELAY + 1, 4);
    send_samples(32);
    set_regs(8191, 5);
    send_samples(32);
    set_regs(0, 0);
    send_samples(32);

    wait_drained();
    if (tap_sb.mismatches == 0 && tap_sb.expected_taps.size() == 0) begin
      $display("PASS crossfading_delay_line");
    end else begin
      $display("FAIL crossfading_delay_line");
    end
    $finish;
  end

endmodule
